// File: design/svsa_pkg.sv
// Shared types and constants for the voice slot allocator.
package svsa_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int NOTE_W   = 8;
    localparam int OCT_W    = 8;
    localparam int VEL_W    = 7;
    localparam int ENTRY_W  = NOTE_W + OCT_W + VEL_W;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int MASK_W   = 16;

    localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_DISABLED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic set;
        logic clr;
    } t_busy_op;

endpackage

// File: design/svsa_if.sv
// Handshake channels of the voice slot allocator: events, results, configuration.
interface svsa_evt_if;
    logic                          valid;
    logic                          ready;
    logic [svsa_pkg::ACTION_W-1:0] action;
    logic [svsa_pkg::NOTE_W-1:0]   note_name;
    logic [svsa_pkg::OCT_W-1:0]    octave;
    logic [svsa_pkg::VEL_W-1:0]    velocity;

    modport source (output valid, action, note_name, octave, velocity, input ready);
    modport sink   (input valid, action, note_name, octave, velocity, output ready);
endinterface

interface svsa_res_if;
    logic                          valid;
    logic                          ready;
    logic [svsa_pkg::STATUS_W-1:0] status;
    logic [svsa_pkg::SLOT_W-1:0]   slot;
    logic [svsa_pkg::MASK_W-1:0]   active_mask;

    modport source (output valid, status, slot, active_mask, input ready);
    modport sink   (input valid, status, slot, active_mask, output ready);
endinterface

interface svsa_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, enable, input ready);
    modport sink   (input valid, enable, output ready);
endinterface

// File: design/svsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/svsa_busy_flags.sv
// Per-slot busy flags with lowest-free-slot search.
module svsa_busy_flags #(
    parameter int NUM_SLOTS = svsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  svsa_pkg::t_busy_op                             i_op,
    input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] i_idx,
    output logic [NUM_SLOTS-1:0]                           o_busy,
    output logic                                           o_any_free,
    output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] o_free_idx
);
    localparam int IW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] n_busy;
    logic [NUM_SLOTS-1:0] w_first_free;
    logic [IW-1:0]        w_free_idx;

    always_comb begin
        n_busy = r_busy;
        if (i_op.set) begin
            n_busy[i_idx] = 1'b1;
        end
        if (i_op.clr) begin
            n_busy[i_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // isolate lowest zero bit as a one-hot vector
    assign w_first_free = ~r_busy & (r_busy + NUM_SLOTS'(1));

    always_comb begin
        w_free_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_first_free[i]) begin
                w_free_idx = w_free_idx | IW'(i);
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_any_free = ~&r_busy;
    assign o_free_idx = w_free_idx;
endmodule

// File: design/synth_voice_slot_allocator_unit.sv
// Top level of the voice slot allocator: event sequencer, slot scan and result register.
//
//   channel  | dir | payload                              | item
//   ---------+-----+--------------------------------------+-------------------
//   i_evt    | in  | action, note_name, octave, velocity  | one MIDI event
//   o_res    | out | status, slot, active_mask            | one result/event
//   i_cfg    | in  | enable                               | one register write
//
// Note-on, ignored and disabled events go straight from S_IDLE to S_DONE, skipping the scan.
// Note-off reads one slot a cycle through the single RAM read port and stops at the first
// match; with no match it reads all NUM_SLOTS slots and reports not-found.
// One event is in work at a time; the next is taken at the edge after the result is loaded,
// even while that result waits on o_res.ready.
// Synchronous reset clears enable and all busy flags; slot contents are not cleared.
module synth_voice_slot_allocator_unit #(
    parameter int NUM_SLOTS = svsa_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    svsa_evt_if.sink          i_evt,
    svsa_res_if.source        o_res,
    svsa_cfg_if.sink          i_cfg
);
    localparam int IW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int XW = IW > svsa_pkg::SLOT_W ? IW : svsa_pkg::SLOT_W;
    localparam int MW = NUM_SLOTS > svsa_pkg::MASK_W ? NUM_SLOTS : svsa_pkg::MASK_W;

    svsa_pkg::t_state  r_state, n_state;
    svsa_pkg::t_status r_status, n_status;
    logic [IW-1:0]     r_slot, n_slot;

    logic                          r_enable;
    logic [svsa_pkg::ACTION_W-1:0] r_action;
    logic [svsa_pkg::NOTE_W-1:0]   r_note;
    logic [svsa_pkg::OCT_W-1:0]    r_oct;

    logic [CW-1:0] r_addr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    logic                          r_out_valid;
    logic [svsa_pkg::STATUS_W-1:0] r_out_status;
    logic [svsa_pkg::SLOT_W-1:0]   r_out_slot;
    logic [svsa_pkg::MASK_W-1:0]   r_out_mask;

    svsa_pkg::t_busy_op            w_busy_op;
    logic [IW-1:0]                 w_busy_idx;
    logic [NUM_SLOTS-1:0]          w_busy;
    logic                          w_any_free;
    logic [IW-1:0]                 w_free_idx;
    logic                          w_ram_we;
    logic [svsa_pkg::ENTRY_W-1:0]  w_rdata;
    logic                          w_issue;
    logic                          w_hit;
    logic                          w_last_miss;
    logic                          w_evt_acc;
    logic                          w_out_load;
    logic [XW-1:0]                 w_slot_ext;
    logic [MW-1:0]                 w_mask_ext;

    assign i_cfg.ready = 1'b1;
    assign i_evt.ready = (r_state == svsa_pkg::S_IDLE);
    assign w_evt_acc   = i_evt.valid && i_evt.ready;
    assign w_out_load  = (r_state == svsa_pkg::S_DONE) && (!r_out_valid || o_res.ready);

    svsa_busy_flags #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_busy (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_busy_op),
        .i_idx      (w_busy_idx),
        .o_busy     (w_busy),
        .o_any_free (w_any_free),
        .o_free_idx (w_free_idx)
    );

    svsa_ram #(
        .WIDTH (svsa_pkg::ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_free_idx),
        .i_wdata ({i_evt.note_name, i_evt.octave, i_evt.velocity}),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // compare the entry read last cycle against the held note-off key
    assign w_hit = r_rd_vld && w_busy[r_rd_idx]
                   && (w_rdata[svsa_pkg::ENTRY_W-1 -: svsa_pkg::NOTE_W + svsa_pkg::OCT_W]
                       == {r_note, r_oct});
    assign w_last_miss = r_rd_vld && !w_hit && (r_rd_idx == IW'(NUM_SLOTS - 1));
    assign w_issue     = (r_state == svsa_pkg::S_SCAN) && (r_addr < CW'(NUM_SLOTS)) && !w_hit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            svsa_pkg::S_IDLE: begin
                if (w_evt_acc) begin
                    if (r_enable && i_evt.action == svsa_pkg::ACT_NOTE_OFF) begin
                        n_state = svsa_pkg::S_SCAN;
                    end else begin
                        n_state = svsa_pkg::S_DONE;
                    end
                end
            end
            svsa_pkg::S_SCAN: begin
                if (w_hit || w_last_miss) begin
                    n_state = svsa_pkg::S_DONE;
                end
            end
            svsa_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = svsa_pkg::S_IDLE;
                end
            end
            default: n_state = svsa_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_busy_op  = '0;
        w_busy_idx = w_free_idx;
        w_ram_we   = 1'b0;
        n_status   = r_status;
        n_slot     = r_slot;
        case (r_state)
            svsa_pkg::S_IDLE: begin
                if (w_evt_acc) begin
                    n_slot = '0;
                    if (!r_enable) begin
                        n_status = svsa_pkg::ST_DISABLED;
                    end else if (i_evt.action == svsa_pkg::ACT_NOTE_ON) begin
                        if (w_any_free) begin
                            w_busy_op.set = 1'b1;
                            w_ram_we      = 1'b1;
                            n_status      = svsa_pkg::ST_ALLOCATED;
                            n_slot        = w_free_idx;
                        end else begin
                            n_status = svsa_pkg::ST_FULL;
                        end
                    end else if (i_evt.action == svsa_pkg::ACT_NOTE_OFF) begin
                        n_status = svsa_pkg::ST_NOTFOUND;
                    end else begin
                        n_status = svsa_pkg::ST_IGNORED;
                    end
                end
            end
            svsa_pkg::S_SCAN: begin
                w_busy_idx = r_rd_idx;
                if (w_hit) begin
                    w_busy_op.clr = 1'b1;
                    n_status      = svsa_pkg::ST_FREED;
                    n_slot        = r_rd_idx;
                end
            end
            svsa_pkg::S_DONE: begin
                w_busy_idx = r_slot;
            end
            default: begin
                w_busy_idx = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svsa_pkg::S_IDLE;
            r_enable    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (i_cfg.valid && i_cfg.ready) begin
                r_enable <= i_cfg.enable;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_slot_ext = XW'(r_slot);
    assign w_mask_ext = MW'(w_busy);

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_rd_idx <= r_addr[IW-1:0];
        if (w_evt_acc) begin
            r_action <= i_evt.action;
            r_note   <= i_evt.note_name;
            r_oct    <= i_evt.octave;
            r_addr   <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + CW'(1);
        end
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_slot   <= w_slot_ext[svsa_pkg::SLOT_W-1:0];
            r_out_mask   <= w_mask_ext[svsa_pkg::MASK_W-1:0];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.slot        = r_out_slot;
    assign o_res.active_mask = r_out_mask;

    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svsa_pkg::S_DONE && r_status == svsa_pkg::ST_ALLOCATED) |-> w_busy[r_slot])
        else $error("allocated slot not marked busy");

    a_freed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svsa_pkg::S_DONE && r_status == svsa_pkg::ST_FREED) |-> !w_busy[r_slot])
        else $error("freed slot still marked busy");

    a_scan_noteoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svsa_pkg::S_SCAN) |-> (r_action == svsa_pkg::ACT_NOTE_OFF && r_enable))
        else $error("slot scan running for an event other than an enabled note-off");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state) == svsa_pkg::S_SCAN)
        else $error("slot read outside a scan");
endmodule

// File: verif/svsa_slot_checker.sv
// Checker for the voice slot allocator: predicts each event's result and compares it.
`timescale 1ns / 100ps
module svsa_slot_checker #(
    parameter int NUM_SLOTS = svsa_pkg::NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    svsa_evt_if  evt_mon,
    svsa_res_if  res_mon,
    svsa_cfg_if  cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import svsa_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [MASK_W-1:0]   active_mask;
    } voice_result_t;

    logic                 synth_on;
    logic [NUM_SLOTS-1:0] voice_busy;
    logic [NOTE_W-1:0]    voice_note [NUM_SLOTS];
    logic [OCT_W-1:0]     voice_oct  [NUM_SLOTS];
    voice_result_t        pending_results[$];
    int                   fail_count = 0;
    int                   pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [MASK_W-1:0] occupancy(input logic [NUM_SLOTS-1:0] busy);
        logic [MASK_W-1:0] m = '0;
        for (int i = 0; i < NUM_SLOTS && i < MASK_W; i++)
            m[i] = busy[i];
        return m;
    endfunction

    // Apply one event to the slot table and return the result it should produce.
    function automatic voice_result_t allocate_voice(input logic [ACTION_W-1:0] act,
                                                     input logic [NOTE_W-1:0]   nt,
                                                     input logic [OCT_W-1:0]    oc);
        voice_result_t r;
        bit            hit = 1'b0;
        r.status = ST_IGNORED;
        r.slot   = '0;
        if (!synth_on) begin
            r.status = ST_DISABLED;
        end else if (act == ACT_NOTE_ON) begin
            r.status = ST_FULL;
            for (int i = 0; i < NUM_SLOTS && !hit; i++) begin
                if (!voice_busy[i]) begin
                    voice_busy[i] = 1'b1;
                    voice_note[i] = nt;
                    voice_oct[i]  = oc;
                    r.status      = ST_ALLOCATED;
                    r.slot        = SLOT_W'(i);
                    hit           = 1'b1;
                end
            end
        end else if (act == ACT_NOTE_OFF) begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < NUM_SLOTS && !hit; i++) begin
                if (voice_busy[i] && voice_note[i] == nt && voice_oct[i] == oc) begin
                    voice_busy[i] = 1'b0;
                    r.status      = ST_FREED;
                    r.slot        = SLOT_W'(i);
                    hit           = 1'b1;
                end
            end
        end
        r.active_mask = occupancy(voice_busy);
        return r;
    endfunction

    always @(posedge i_clk) begin
        voice_result_t want;
        if (!i_rst_n) begin
            synth_on   = 1'b0;
            voice_busy = '0;
            pending_results.delete();
        end else begin
            // A result never belongs to an event taken at the same edge: pop first.
            if (res_mon.valid && res_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d active_mask %h",
                           res_mon.status, res_mon.slot, res_mon.active_mask);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_mon.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, res_mon.status);
                        fail_count++;
                    end
                    if (res_mon.slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want.slot, res_mon.slot);
                        fail_count++;
                    end
                    if (res_mon.active_mask !== want.active_mask) begin
                        $error("active_mask mismatch: expected %h, actual %h",
                               want.active_mask, res_mon.active_mask);
                        fail_count++;
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
                synth_on = cfg_mon.enable;
            if (evt_mon.valid && evt_mon.ready)
                pending_results.push_back(allocate_voice(evt_mon.action, evt_mon.note_name,
                                                         evt_mon.octave));
        end
        pending = pending_results.size();
    end

endmodule

// File: verif/synth_voice_slot_allocator_unit_tb.sv
// Top of the voice slot allocator testbench: clock, reset, event stimulus and verdict.
`timescale 1ns / 100ps
module synth_voice_slot_allocator_unit_tb;
    import svsa_pkg::*;

    localparam int NUM_SLOTS     = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
    localparam int PHASE_ITEMS   = 440;

    localparam logic [ACTION_W-1:0] ACT_OTHER  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   snd_idle_pct = 0;
    int   rcv_stall_pct = 0;

    svsa_evt_if evt_ch ();
    svsa_res_if res_ch ();
    svsa_cfg_if cfg_ch ();

    synth_voice_slot_allocator_unit #(.NUM_SLOTS(NUM_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    svsa_slot_checker #(.NUM_SLOTS(NUM_SLOTS)) slot_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .evt_mon      (evt_ch),
        .res_mon      (res_ch),
        .cfg_mon      (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [NOTE_W-1:0] nt,
                              input logic [OCT_W-1:0] oc, input logic [VEL_W-1:0] vel);
        if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            evt_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.action    <= act;
        evt_ch.note_name <= nt;
        evt_ch.octave    <= oc;
        evt_ch.velocity  <= vel;
        do @(posedge i_clk); while (!evt_ch.ready);
    endtask

    // Hold off the sender until every result is back and the block is quiet.
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.enable <= en;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly a narrow note set so note-offs find their voices; the rest spans all codes.
    task automatic send_random_event(input int on_pct);
        int                  roll;
        logic [ACTION_W-1:0] act;
        logic [NOTE_W-1:0]   nt;
        logic [OCT_W-1:0]    oc;
        roll = $urandom_range(99);
        if (roll < 8)
            act = $urandom_range(1) ? ACT_OTHER : ACT_UNUSED;
        else if (roll < 8 + on_pct * 92 / 100)
            act = ACT_NOTE_ON;
        else
            act = ACT_NOTE_OFF;
        if ($urandom_range(99) < 85) begin
            nt = NOTE_W'($urandom_range(3));
            oc = OCT_W'($urandom_range(1));
        end else begin
            nt = NOTE_W'($urandom);
            oc = OCT_W'($urandom);
        end
        send_event(act, nt, oc, VEL_W'($urandom));
    endtask

    initial begin
        int on_pct;
        int idle_set [4] = '{0, 85, 0, 23};
        int stall_set[4] = '{0, 0, 85, 23};
        on_pct = 50;
        i_rst_n          <= 1'b0;
        evt_ch.valid     <= 1'b0;
        evt_ch.action    <= ACT_NOTE_OFF;
        evt_ch.note_name <= '0;
        evt_ch.octave    <= '0;
        evt_ch.velocity  <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.enable    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // enable is clear out of reset
        send_event(ACT_NOTE_ON, 8'd60, 8'd4, 7'd100);
        send_event(ACT_NOTE_OFF, 8'd60, 8'd4, 7'd0);
        drain_results();
        write_enable(1'b1);

        send_event(ACT_NOTE_ON, '0, '0, '0);
        send_event(ACT_NOTE_ON, '1, '1, '1);
        send_event(ACT_NOTE_OFF, 8'd1, 8'd0, '1);
        send_event(ACT_OTHER, '1, '1, '1);
        send_event(ACT_UNUSED, '0, '0, '0);
        send_event(ACT_NOTE_OFF, '1, '1, '0);
        send_event(ACT_NOTE_OFF, '0, '0, '1);
        // fill every slot with repeated notes, then overflow
        for (int i = 0; i < NUM_SLOTS; i++)
            send_event(ACT_NOTE_ON, NOTE_W'(i % 3), 8'd5, VEL_W'(i * 8));
        send_event(ACT_NOTE_ON, 8'd9, 8'd9, 7'd9);
        send_event(ACT_NOTE_OFF, 8'd1, 8'd5, 7'd0);
        send_event(ACT_NOTE_OFF, 8'd2, 8'd4, 7'd0);
        drain_results();
        write_enable(1'b0);
        send_event(ACT_NOTE_ON, 8'd7, 8'd7, 7'd7);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            snd_idle_pct  = idle_set[phase];
            rcv_stall_pct = stall_set[phase];
            drain_results();
            write_enable(1'b1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    on_pct = 25 * $urandom_range(1, 3);
                if (n == 220)
                    drain_results();
                if (n == 300 && phase % 2 == 1) begin
                    drain_results();
                    write_enable(1'b0);
                end
                if (n == 330 && phase % 2 == 1) begin
                    drain_results();
                    write_enable(1'b1);
                end
                send_random_event(on_pct);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
design/svsa_pkg.sv
design/svsa_if.sv
design/svsa_ram.sv
design/svsa_busy_flags.sv
design/synth_voice_slot_allocator_unit.sv
verif/svsa_slot_checker.sv
verif/synth_voice_slot_allocator_unit_tb.sv
